// ----- design/rbd_pkg.sv -----
package rbd_pkg;

	// store geometry
	localparam int DEPTH   = 1024;
	localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int COUNT_W = 11;
	localparam int WORD_W  = 32;

	// action codes
	typedef enum logic [2:0] {
		ACT_NONE       = 3'd0,
		ACT_PUSH_FRONT = 3'd1,
		ACT_PUSH_BACK  = 3'd2,
		ACT_POP_FRONT  = 3'd3,
		ACT_POP_BACK   = 3'd4
	} action_t;

	// status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// input item
	typedef struct packed {
		logic [2:0]               action;
		logic signed [WORD_W-1:0] push_value;
	} req_item_t;

	// result item
	typedef struct packed {
		logic signed [WORD_W-1:0] popped_value;
		logic [1:0]               status;
		logic [COUNT_W-1:0]       item_count;
		logic                     is_empty;
		logic signed [WORD_W-1:0] front_value;
		logic signed [WORD_W-1:0] back_value;
	} rsp_item_t;

	// controller to datapath commands
	typedef struct packed {
		logic accept;
		logic rd_en;
		logic out_valid;
	} cmd_t;

	// circular pointer step forward
	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
		return r;
	endfunction

	// circular pointer step back
	function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		r = (p == '0) ? PTR_W'(DEPTH - 1) : p - PTR_W'(1);
		return r;
	endfunction

endpackage

// ----- design/ring_buffer_deque_unit.sv -----
// Double-ended queue of 32-bit values in a circular store of 1024 entries.
// Command channel: an item (action plus push value on req) is taken at a
// rising edge where start is high and busy is low. Actions are none, push
// front, push back, pop front and pop back; other codes act as none.
// Result channel: every item yields one result on rsp, marked by done for
// exactly one cycle. It carries the popped value, a status (ok, full,
// empty), and the count, empty flag, front and back values after the item.
// After acceptance the sequencer moves to its read state, then to its
// output state, where done is high. The cycle after acceptance reads the
// new front and back entries from the store (one registered read per
// value), so busy is high for that one cycle and no item is taken; a new
// item may be taken in the same cycle its predecessor's result is shown.
// The receiver cannot stall: a result not taken in its done cycle is gone.
// Reset clears the pointers and count, so the deque starts empty; the
// store contents need no clearing since only held entries are ever shown.
module ring_buffer_deque_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  rbd_pkg::req_item_t req,
	output logic               done,
	output rbd_pkg::rsp_item_t rsp
);

	rbd_pkg::cmd_t cmd;

	// sequencer
	rbd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	// store, pointers and result registers
	rbd_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

	assign done = cmd.out_valid;

endmodule

// ----- design/rbd_ctrl.sv -----
module rbd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output rbd_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_READ = 3'b010,
		S_OUT  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_next;
	logic   accept;

	// handshake
	assign busy   = (state_q == S_READ);
	assign accept = start && !busy;

	// next state
	always_comb begin
		case (state_q)
			S_IDLE:  state_next = accept ? S_READ : S_IDLE;
			S_READ:  state_next = S_OUT;
			S_OUT:   state_next = accept ? S_READ : S_IDLE;
			default: state_next = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// commands to datapath
	assign cmd.accept    = accept;
	assign cmd.rd_en     = (state_q == S_READ);
	assign cmd.out_valid = (state_q == S_OUT);

endmodule

// ----- design/rbd_datapath.sv -----
module rbd_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  rbd_pkg::cmd_t      cmd,
	input  rbd_pkg::req_item_t req,
	output rbd_pkg::rsp_item_t rsp
);

	logic [rbd_pkg::WORD_W-1:0] mem [rbd_pkg::DEPTH];

	logic [rbd_pkg::PTR_W-1:0]  head_q;
	logic [rbd_pkg::PTR_W-1:0]  tail_q;
	logic [rbd_pkg::CNT_W-1:0]  count_q;
	logic [rbd_pkg::WORD_W-1:0] front_q;
	logic [rbd_pkg::WORD_W-1:0] back_q;
	logic [rbd_pkg::WORD_W-1:0] popped_q;
	rbd_pkg::status_t           status_q;

	logic [rbd_pkg::PTR_W-1:0]  head_next;
	logic [rbd_pkg::PTR_W-1:0]  tail_next;
	logic [rbd_pkg::CNT_W-1:0]  count_next;
	logic [rbd_pkg::WORD_W-1:0] popped_next;
	rbd_pkg::status_t           status_next;
	logic                       we;
	logic [rbd_pkg::PTR_W-1:0]  waddr;
	logic                       full;
	logic                       empty;
	logic                       is_empty;

	assign full  = (count_q == rbd_pkg::CNT_W'(rbd_pkg::DEPTH));
	assign empty = (count_q == '0);

	// action decode
	always_comb begin
		head_next   = head_q;
		tail_next   = tail_q;
		count_next  = count_q;
		popped_next = '0;
		status_next = rbd_pkg::ST_OK;
		we          = 1'b0;
		waddr       = tail_q;
		case (req.action)
			rbd_pkg::ACT_PUSH_FRONT: begin
				if (full) begin
					status_next = rbd_pkg::ST_FULL;
				end else begin
					head_next  = rbd_pkg::ptr_dec(head_q);
					waddr      = rbd_pkg::ptr_dec(head_q);
					we         = 1'b1;
					count_next = count_q + rbd_pkg::CNT_W'(1);
				end
			end
			rbd_pkg::ACT_PUSH_BACK: begin
				if (full) begin
					status_next = rbd_pkg::ST_FULL;
				end else begin
					waddr      = tail_q;
					we         = 1'b1;
					tail_next  = rbd_pkg::ptr_inc(tail_q);
					count_next = count_q + rbd_pkg::CNT_W'(1);
				end
			end
			rbd_pkg::ACT_POP_FRONT: begin
				if (empty) begin
					status_next = rbd_pkg::ST_EMPTY;
				end else begin
					popped_next = front_q;
					head_next   = rbd_pkg::ptr_inc(head_q);
					count_next  = count_q - rbd_pkg::CNT_W'(1);
				end
			end
			rbd_pkg::ACT_POP_BACK: begin
				if (empty) begin
					status_next = rbd_pkg::ST_EMPTY;
				end else begin
					popped_next = back_q;
					tail_next   = rbd_pkg::ptr_dec(tail_q);
					count_next  = count_q - rbd_pkg::CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (cmd.accept) begin
			head_q  <= head_next;
			tail_q  <= tail_next;
			count_q <= count_next;
		end
	end

	// per-item result fields
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			popped_q <= popped_next;
			status_q <= status_next;
		end
	end

	// value store write port
	always_ff @(posedge clk) begin
		if (cmd.accept && we) begin
			mem[waddr] <= req.push_value;
		end
	end

	// value store read ports for new front and back
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			front_q <= mem[head_q];
			back_q  <= mem[rbd_pkg::ptr_dec(tail_q)];
		end
	end

	// result assembly
	assign is_empty         = empty;
	assign rsp.popped_value = popped_q;
	assign rsp.status       = status_q;
	assign rsp.item_count   = rbd_pkg::COUNT_W'(count_q);
	assign rsp.is_empty     = is_empty;
	assign rsp.front_value  = is_empty ? '0 : front_q;
	assign rsp.back_value   = is_empty ? '0 : back_q;

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;

	// spare action codes, treated as a query by the block
	localparam logic [2:0] ACT_RSV0 = 3'd5;
	localparam logic [2:0] ACT_RSV1 = 3'd6;
	localparam logic [2:0] ACT_RSV2 = 3'd7;

	localparam int ITEM_TARGET   = 1700;
	localparam int IDLE_PCT      = 8;
	localparam int CALM_FIRST    = 400;
	localparam int CALM_LAST     = 900;
	localparam int SETTLE_CYCLES = 8;
	localparam int LIMIT_CYCLES  = 200000;

	typedef struct {
		bit                 hold;
		rbd_pkg::req_item_t item;
	} pending_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	rbd_pkg::req_item_t req = '0;
	logic               busy;
	logic               done;
	rbd_pkg::rsp_item_t rsp;

	pending_t           pending_items[$];
	rbd_pkg::rsp_item_t expected_results[$];
	rbd_pkg::rsp_item_t oldest;
	int                 queued_depth = 0;
	int                 items_sent = 0;
	int                 results_seen;
	int                 mismatch_count = 0;

	// shadow copy of the deque
	logic [rbd_pkg::WORD_W-1:0] shadow_store [rbd_pkg::DEPTH];
	int                         front_idx = 0;
	int                         back_idx = 0;
	int                         held = 0;

	ring_buffer_deque_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// apply one item to the shadow deque and return the result it should give
	function automatic rbd_pkg::rsp_item_t deque_step(rbd_pkg::req_item_t it);
		rbd_pkg::rsp_item_t r;
		r = '0;
		r.status = rbd_pkg::ST_OK;
		case (it.action)
			rbd_pkg::ACT_PUSH_FRONT: begin
				if (held == rbd_pkg::DEPTH) begin
					r.status = rbd_pkg::ST_FULL;
				end else begin
					front_idx = (front_idx + rbd_pkg::DEPTH - 1) % rbd_pkg::DEPTH;
					shadow_store[front_idx] = it.push_value;
					held++;
				end
			end
			rbd_pkg::ACT_PUSH_BACK: begin
				if (held == rbd_pkg::DEPTH) begin
					r.status = rbd_pkg::ST_FULL;
				end else begin
					shadow_store[back_idx] = it.push_value;
					back_idx = (back_idx + 1) % rbd_pkg::DEPTH;
					held++;
				end
			end
			rbd_pkg::ACT_POP_FRONT: begin
				if (held == 0) begin
					r.status = rbd_pkg::ST_EMPTY;
				end else begin
					r.popped_value = shadow_store[front_idx];
					front_idx = (front_idx + 1) % rbd_pkg::DEPTH;
					held--;
				end
			end
			rbd_pkg::ACT_POP_BACK: begin
				if (held == 0) begin
					r.status = rbd_pkg::ST_EMPTY;
				end else begin
					back_idx = (back_idx + rbd_pkg::DEPTH - 1) % rbd_pkg::DEPTH;
					r.popped_value = shadow_store[back_idx];
					held--;
				end
			end
			default: begin
			end
		endcase
		r.item_count = rbd_pkg::COUNT_W'(held);
		r.is_empty = (held == 0);
		// ends read as zero once the deque is empty
		if (held != 0) begin
			r.front_value = shadow_store[front_idx];
			r.back_value = shadow_store[(back_idx + rbd_pkg::DEPTH - 1) % rbd_pkg::DEPTH];
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [rbd_pkg::WORD_W-1:0] got,
		logic [rbd_pkg::WORD_W-1:0] want);
		$display("mismatch on result %0d, %s: got %h, want %h", results_seen, what, got, want);
		mismatch_count++;
	endtask

	task automatic check_field(string what, logic [rbd_pkg::WORD_W-1:0] got,
		logic [rbd_pkg::WORD_W-1:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// generator side: keep a running count so fills and drains can be steered
	task automatic queue_item(logic [2:0] act, logic [rbd_pkg::WORD_W-1:0] val);
		pending_t p;
		p.hold = 1'b0;
		p.item.action = act;
		p.item.push_value = val;
		pending_items = {pending_items, p};
		if ((act == rbd_pkg::ACT_PUSH_FRONT || act == rbd_pkg::ACT_PUSH_BACK) &&
			queued_depth < rbd_pkg::DEPTH)
			queued_depth++;
		else if ((act == rbd_pkg::ACT_POP_FRONT || act == rbd_pkg::ACT_POP_BACK) &&
			queued_depth > 0)
			queued_depth--;
	endtask

	task automatic queue_pause();
		pending_t p;
		p.hold = 1'b1;
		p.item = '0;
		pending_items = {pending_items, p};
	endtask

	task automatic queue_random(int n, int push_pct);
		logic [2:0]                 act;
		logic [rbd_pkg::WORD_W-1:0] val;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 6) begin
				case ($urandom_range(3))
					0: act = rbd_pkg::ACT_NONE;
					1: act = ACT_RSV0;
					2: act = ACT_RSV1;
					default: act = ACT_RSV2;
				endcase
			end else if ($urandom_range(99) < push_pct) begin
				act = $urandom_range(1) ? rbd_pkg::ACT_PUSH_FRONT : rbd_pkg::ACT_PUSH_BACK;
			end else begin
				act = $urandom_range(1) ? rbd_pkg::ACT_POP_FRONT : rbd_pkg::ACT_POP_BACK;
			end
			// mostly random words, some extremes
			case ($urandom_range(19))
				0: val = 32'h8000_0000;
				1: val = 32'h7fff_ffff;
				2: val = 32'hffff_ffff;
				3: val = 32'h0000_0000;
				default: val = $urandom;
			endcase
			queue_item(act, val);
		end
	endtask

	// driver: present the next item once the current one is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
		end else begin
			if (start && !busy) begin
				expected_results = {expected_results, deque_step(req)};
				items_sent++;
			end
			if (!start || !busy) begin
				if (pending_items.size() > 0 && pending_items[0].hold) begin
					// hold off until every outstanding result is back
					if (items_sent == results_seen)
						pending_items.delete(0);
					start <= 1'b0;
				end else if (pending_items.size() > 0 &&
					((items_sent >= CALM_FIRST && items_sent < CALM_LAST) ||
					$urandom_range(99) >= IDLE_PCT)) begin
					req <= pending_items[0].item;
					pending_items.delete(0);
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: every done cycle carries one result
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_seen <= 0;
		end else if (done) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", rsp.popped_value, '0);
			end else begin
				oldest = expected_results[0];
				expected_results.delete(0);
				check_field("popped_value", rsp.popped_value, oldest.popped_value);
				check_field("status", rsp.status, oldest.status);
				check_field("item_count", rsp.item_count, oldest.item_count);
				check_field("is_empty", rsp.is_empty, oldest.is_empty);
				check_field("front_value", rsp.front_value, oldest.front_value);
				check_field("back_value", rsp.back_value, oldest.back_value);
			end
			results_seen <= results_seen + 1;
		end
	end

	initial begin
		#(LIMIT_CYCLES * 8);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		// empty deque: query and pops on both ends
		queue_item(rbd_pkg::ACT_NONE, 32'h0000_0001);
		queue_item(rbd_pkg::ACT_POP_FRONT, 32'hffff_ffff);
		queue_item(rbd_pkg::ACT_POP_BACK, 32'h0000_0000);
		// push extremes at both ends, front pointer wraps at once
		queue_item(rbd_pkg::ACT_PUSH_FRONT, 32'h7fff_ffff);
		queue_item(rbd_pkg::ACT_PUSH_BACK, 32'h8000_0000);
		queue_item(rbd_pkg::ACT_PUSH_FRONT, 32'hffff_ffff);
		queue_item(rbd_pkg::ACT_PUSH_BACK, 32'h0000_0000);
		queue_item(rbd_pkg::ACT_NONE, 32'h5a5a_5a5a);
		// spare codes act as a query
		queue_item(ACT_RSV0, 32'hffff_ffff);
		queue_item(ACT_RSV1, 32'h1234_5678);
		queue_item(ACT_RSV2, 32'h8000_0000);
		// drain from both ends, then pop each end once more on empty
		queue_item(rbd_pkg::ACT_POP_BACK, 32'h0000_0000);
		queue_item(rbd_pkg::ACT_POP_FRONT, 32'h0000_0000);
		queue_item(rbd_pkg::ACT_POP_FRONT, 32'h0000_0000);
		queue_item(rbd_pkg::ACT_POP_BACK, 32'h0000_0000);
		queue_item(rbd_pkg::ACT_POP_BACK, 32'h0000_0000);
		queue_item(rbd_pkg::ACT_POP_FRONT, 32'h0000_0000);
		// single entry: front and back are the same value
		queue_item(rbd_pkg::ACT_PUSH_BACK, 32'h1234_5678);
		queue_item(rbd_pkg::ACT_POP_FRONT, 32'h0000_0000);
		queue_item(rbd_pkg::ACT_PUSH_FRONT, 32'ha5a5_a5a5);
		queue_item(rbd_pkg::ACT_POP_BACK, 32'h0000_0000);
		queue_pause();

		// balanced mix that keeps hitting the empty deque
		queue_random(330, 50);
		queue_pause();
		// fill to capacity, then work around the full deque
		while (queued_depth < rbd_pkg::DEPTH)
			queue_random(1, 95);
		queue_random(40, 70);
		queue_pause();
		// pop-heavy tail
		queue_random((pending_items.size() < ITEM_TARGET - 100) ?
			ITEM_TARGET - pending_items.size() : 100, 40);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do
			@(negedge clk);
		while (pending_items.size() != 0 || start || items_sent != results_seen);
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (mismatch_count == 0 && expected_results.size() == 0 && items_sent == results_seen)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
design/rbd_pkg.sv
design/rbd_ctrl.sv
design/rbd_datapath.sv
design/ring_buffer_deque_unit.sv
tb/sv/tb_top.sv
